### src/linear_scan_priority_queue_macros.svh
// Assertion macros for the linear scan priority queue
`ifndef LINEAR_SCAN_PRIORITY_QUEUE_MACROS_SVH
`define LINEAR_SCAN_PRIORITY_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
`define LSQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lsq assertion failed");
`define LSQ_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lsq assertion failed");
`else
`define LSQ_ASSERT_IMP(label, clk, rst, ante, cons)
`define LSQ_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

### src/lsq_pkg.sv
// Types, constants and state codes for the linear scan priority queue
`timescale 1ns / 1ps
package lsq_pkg;
   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CAP_W = 5;
   localparam int FILL_W = 5;
   localparam int PRI_W = 16;
   localparam int VAL_W = 32;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   localparam logic K_ENQ = 1'b0;
   localparam logic K_DEQ = 1'b1;

   typedef struct packed {
      logic kind;
      logic signed [VAL_W-1:0] item_value;
      logic [PRI_W-1:0] item_priority;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic signed [VAL_W-1:0] out_value;
      logic [FILL_W-1:0] fill;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic sample;
   } cmp_ctl_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_LAST,
      S_BEST,
      S_MOVE
   } state_type;
endpackage

### src/lsq_cmp.sv
// Compare unit that tracks the best priority seen during a scan
`timescale 1ns / 1ps
module lsq_cmp (
   input  logic                         clock,
   input  lsq_pkg::cmp_ctl_type         ctl,
   input  logic [lsq_pkg::PRI_W-1:0]    pri,
   input  logic [lsq_pkg::IDX_W-1:0]    idx,
   output logic [lsq_pkg::IDX_W-1:0]    best_idx
);
   logic [lsq_pkg::PRI_W-1:0] best_pri_ff, best_pri_in;
   logic [lsq_pkg::IDX_W-1:0] best_idx_ff, best_idx_in;

   always_comb begin
      best_pri_in = best_pri_ff;
      best_idx_in = best_idx_ff;
      if (ctl.clear) begin
         best_pri_in = '0;
         best_idx_in = '0;
      end else if (ctl.sample && (pri > best_pri_ff)) begin
         best_pri_in = pri;
         best_idx_in = idx;
      end
   end

   always_ff @(posedge clock) begin
      best_pri_ff <= best_pri_in;
      best_idx_ff <= best_idx_in;
   end

   assign best_idx = best_idx_ff;
endmodule

### src/linear_scan_priority_queue.sv
// Enqueue and empty dequeue answer in the cycle after the transfer.
// Dequeue walks the scan, last, best and move states; the scan reads one
// stored priority per cycle through the single memory read port.
// A new request is taken once the answer register is free and the block idle.
// Synchronous reset empties the queue and sets capacity to 16; no clearing pass.
`timescale 1ns / 1ps
`include "linear_scan_priority_queue_macros.svh"
module linear_scan_priority_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  lsq_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output lsq_pkg::rsp_type             rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [lsq_pkg::CAP_W-1:0]    csr_data
);
   logic [lsq_pkg::PRI_W-1:0] pri_mem_ff [lsq_pkg::DEPTH];
   logic [lsq_pkg::VAL_W-1:0] val_mem_ff [lsq_pkg::DEPTH];

   lsq_pkg::state_type state_ff, state_in;
   logic [lsq_pkg::CNT_W-1:0] count_ff, count_in;
   logic [lsq_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [lsq_pkg::CAP_W-1:0] cap_ff;
   logic rsp_valid_ff, rsp_valid_in;
   lsq_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic rd_vld_ff, rd_vld_in;
   logic [lsq_pkg::IDX_W-1:0] rd_idx_ff;
   logic [lsq_pkg::PRI_W-1:0] pri_rd_ff;
   logic [lsq_pkg::VAL_W-1:0] val_rd_ff;
   logic [lsq_pkg::PRI_W-1:0] last_pri_ff, last_pri_in;
   logic [lsq_pkg::VAL_W-1:0] last_val_ff, last_val_in;

   logic [lsq_pkg::IDX_W-1:0] raddr;
   logic [lsq_pkg::IDX_W-1:0] waddr;
   logic [lsq_pkg::IDX_W-1:0] last_idx;
   logic [lsq_pkg::IDX_W-1:0] best_idx;
   logic [lsq_pkg::PRI_W-1:0] wpri;
   logic [lsq_pkg::VAL_W-1:0] wval;
   logic we;
   logic full;
   logic req_xfer;
   logic rsp_free;
   lsq_pkg::cmp_ctl_type ctl;

   assign csr_ready = 1'b1;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == lsq_pkg::S_IDLE) && rsp_free;
   assign req_xfer = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
   assign last_idx = lsq_pkg::IDX_W'(count_ff - 1'b1);
   assign full = (16'(count_ff) >= 16'(cap_ff))
              || (count_ff >= lsq_pkg::CNT_W'(lsq_pkg::DEPTH));

   lsq_cmp u_cmp (
      .clock    (clock),
      .ctl      (ctl),
      .pri      (pri_rd_ff),
      .idx      (rd_idx_ff),
      .best_idx (best_idx)
   );

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      rd_vld_in = 1'b0;
      raddr = idx_ff;
      we = 1'b0;
      waddr = best_idx;
      wpri = last_pri_ff;
      wval = last_val_ff;
      last_pri_in = last_pri_ff;
      last_val_in = last_val_ff;
      ctl = '0;
      ctl.sample = rd_vld_ff;
      case (state_ff)
         lsq_pkg::S_IDLE: begin
            if (req_xfer) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.out_value = '0;
               rsp_data_in.fill = lsq_pkg::FILL_W'(count_ff);
               if (req_data.kind == lsq_pkg::K_ENQ) begin
                  if (full) begin
                     rsp_data_in.status = lsq_pkg::ST_FULL;
                  end else begin
                     we = 1'b1;
                     waddr = lsq_pkg::IDX_W'(count_ff);
                     wpri = req_data.item_priority;
                     wval = req_data.item_value;
                     count_in = count_ff + 1'b1;
                     rsp_data_in.status = lsq_pkg::ST_OK;
                     rsp_data_in.fill = lsq_pkg::FILL_W'(count_ff + 1'b1);
                  end
               end else if (count_ff == '0) begin
                  rsp_data_in.status = lsq_pkg::ST_EMPTY;
               end else begin
                  rsp_valid_in = 1'b0;
                  rsp_data_in = rsp_data_ff;
                  ctl.clear = 1'b1;
                  idx_in = '0;
                  state_in = lsq_pkg::S_SCAN;
               end
            end
         end
         lsq_pkg::S_SCAN: begin
            raddr = idx_ff;
            rd_vld_in = 1'b1;
            if (idx_ff == last_idx) begin
               state_in = lsq_pkg::S_LAST;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         lsq_pkg::S_LAST: begin
            raddr = last_idx;
            state_in = lsq_pkg::S_BEST;
         end
         lsq_pkg::S_BEST: begin
            raddr = best_idx;
            last_pri_in = pri_rd_ff;
            last_val_in = val_rd_ff;
            state_in = lsq_pkg::S_MOVE;
         end
         lsq_pkg::S_MOVE: begin
            raddr = best_idx;
            if (rsp_free) begin
               we = 1'b1;
               count_in = count_ff - 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in.status = lsq_pkg::ST_OK;
               rsp_data_in.out_value = val_rd_ff;
               rsp_data_in.fill = lsq_pkg::FILL_W'(count_ff - 1'b1);
               state_in = lsq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = lsq_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lsq_pkg::S_IDLE;
         count_ff <= '0;
         cap_ff <= lsq_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff <= rd_vld_in;
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      rsp_data_ff <= rsp_data_in;
      rd_idx_ff <= raddr;
      last_pri_ff <= last_pri_in;
      last_val_ff <= last_val_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         pri_mem_ff[waddr] <= wpri;
         val_mem_ff[waddr] <= wval;
      end
      pri_rd_ff <= pri_mem_ff[raddr];
      val_rd_ff <= val_mem_ff[raddr];
   end

   `LSQ_ASSERT_IMP(a_count_bound, clock, reset, 1'b1,
      16'(count_ff) <= 16'(lsq_pkg::DEPTH))
   `LSQ_ASSERT_IMP(a_busy_nonempty, clock, reset, state_ff != lsq_pkg::S_IDLE,
      count_ff != '0)
   `LSQ_ASSERT_NXT(a_enq_grows, clock, reset,
      req_xfer && (req_data.kind == lsq_pkg::K_ENQ) && !full,
      (count_ff == $past(count_ff) + 1'b1) && rsp_valid_ff)
   `LSQ_ASSERT_NXT(a_deq_shrinks, clock, reset,
      (state_ff == lsq_pkg::S_MOVE) && rsp_free,
      (count_ff == $past(count_ff) - 1'b1) && rsp_valid_ff
      && (state_ff == lsq_pkg::S_IDLE))
endmodule
